// ----- rtl/order_fifo_with_cancel_defines.svh -----
// ----------------------------------------------------------------------------
// Order FIFO with cancel: assertion macros
// Concurrent assertion helpers used by the RTL modules of the order queue.
// ----------------------------------------------------------------------------
`ifndef ORDER_FIFO_WITH_CANCEL_DEFINES_SVH
`define ORDER_FIFO_WITH_CANCEL_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define OFC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define OFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OFC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define OFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/ofc_pkg.sv -----
// ----------------------------------------------------------------------------
// Order FIFO with cancel: package
// Field widths, operation and status codes, and shared structures.
// ----------------------------------------------------------------------------
package ofc_pkg;

   localparam int ID_W    = 31;
   localparam int QTY_W   = 31;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 3;
   localparam int CNT_W   = 7;
   localparam int SUM_W   = 40;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = STAT_W + 4 * ID_W + CNT_W + SUM_W;
   localparam int RSP_PAD = ((RSP_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND     = 2'd0,
      MODE_POP_FRONT  = 2'd1,
      MODE_POP_BACK   = 2'd2,
      MODE_CANCEL     = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_DUP       = 3'd4
   } status_type;

   // Per-slot control from the queue controller.
   typedef struct packed {
      logic shift;
      logic load;
   } slot_ctrl_type;

   // Result record; the last listed field (status) sits in the lowest bits.
   typedef struct packed {
      logic [SUM_W-1:0] total_qty;
      logic [CNT_W-1:0] entry_count;
      logic [QTY_W-1:0] front_qty;
      logic [ID_W-1:0]  front_id;
      logic [QTY_W-1:0] removed_qty;
      logic [ID_W-1:0]  removed_id;
      status_type       status;
   } rsp_type;

endpackage

// ----- rtl/ofc_slot.sv -----
// ----------------------------------------------------------------------------
// Order FIFO with cancel: queue slot
// One position of the compacted queue. Holds an order, compares its id with
// the incoming transaction, and either keeps, loads or takes its neighbor.
// ----------------------------------------------------------------------------
module ofc_slot (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  ofc_pkg::slot_ctrl_type    ctrl,
   input  logic [ofc_pkg::ID_W-1:0]  req_id,
   input  logic [ofc_pkg::QTY_W-1:0] req_qty,
   input  logic [ofc_pkg::ID_W-1:0]  nb_id,
   input  logic [ofc_pkg::QTY_W-1:0] nb_qty,
   input  logic                      nb_valid,
   output logic [ofc_pkg::ID_W-1:0]  id,
   output logic [ofc_pkg::QTY_W-1:0] qty,
   output logic                      valid,
   output logic                      hit,
   output logic [ofc_pkg::ID_W-1:0]  nxt_id,
   output logic [ofc_pkg::QTY_W-1:0] nxt_qty,
   output logic                      nxt_valid
);

   logic [ofc_pkg::ID_W-1:0]  id_ff, id_in;
   logic [ofc_pkg::QTY_W-1:0] qty_ff, qty_in;
   logic                      valid_ff, valid_in;

   always_comb begin
      id_in    = id_ff;
      qty_in   = qty_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         id_in    = nb_id;
         qty_in   = nb_qty;
         valid_in = nb_valid;
      end else if (ctrl.load) begin
         id_in    = req_id;
         qty_in   = req_qty;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         id_ff  <= id_in;
         qty_ff <= qty_in;
      end
   end

   assign id        = id_ff;
   assign qty       = qty_ff;
   assign valid     = valid_ff;
   assign hit       = valid_ff && (id_ff == req_id);
   assign nxt_id    = id_in;
   assign nxt_qty   = qty_in;
   assign nxt_valid = valid_in;

endmodule

// ----- rtl/ofc_out_buf.sv -----
// ----------------------------------------------------------------------------
// Order FIFO with cancel: result buffer
// Output register with a skid stage, so a new transaction is taken while a
// finished result still waits on the result channel.
// ----------------------------------------------------------------------------
`include "order_fifo_with_cancel_defines.svh"

module ofc_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [ofc_pkg::RSP_W-1:0] in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [ofc_pkg::RSP_W-1:0] out_data
);

   logic                      main_valid_ff, main_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic [ofc_pkg::RSP_W-1:0] main_ff, main_in;
   logic [ofc_pkg::RSP_W-1:0] skid_ff, skid_in;
   logic                      take;
   logic                      put;

   assign in_ready = !skid_valid_ff;
   assign take     = main_valid_ff && out_ready;
   assign put      = in_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = put;
         end
      end else if (put) begin
         if (main_valid_ff) begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   `OFC_ASSERT_IMPLIES(a_skid_has_main, clock, reset, skid_valid_ff, main_valid_ff)
   `OFC_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !out_ready, skid_valid_ff)
   `OFC_ASSERT_NEXT(a_stall_fills_skid, clock, reset, put && main_valid_ff && !out_ready, skid_valid_ff)

endmodule

// ----- rtl/order_fifo_with_cancel.sv -----
// A transaction's result is registered into the result buffer when req accepts it.
// One transaction per cycle while req_tready is high; all four modes finish on accept.
// The id search of a cancel or append compares all slots at once in the slot row.
// A two-entry result buffer keeps req_tready high while one result waits.
// Reset (synchronous) empties the queue, count and total at once; no clearing pass.
// ----------------------------------------------------------------------------
// Order FIFO with cancel: top level
// Arrival-ordered queue of orders with append, pop front, pop back and
// cancel by id, reporting count and total quantity after each transaction.
// ----------------------------------------------------------------------------
`include "order_fifo_with_cancel_defines.svh"

module order_fifo_with_cancel #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [1:0] mode, [32:2] order_id, [63:33] order_qty
   input  logic [ofc_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [2:0] status, [33:3] removed_id, [64:34] removed_qty, [95:65] front_id,
   // [126:96] front_qty, [133:127] entry_count, [173:134] total_qty, rest zero
   output logic [ofc_pkg::RSP_PAD-1:0] rsp_tdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   ofc_pkg::mode_type         mode;
   logic [ofc_pkg::ID_W-1:0]  req_id;
   logic [ofc_pkg::QTY_W-1:0] req_qty;
   logic                      req_acc;

   logic [ofc_pkg::ID_W-1:0]  slot_id  [QUEUE_DEPTH];
   logic [ofc_pkg::QTY_W-1:0] slot_qty [QUEUE_DEPTH];
   logic [ofc_pkg::ID_W-1:0]  nb_id    [QUEUE_DEPTH];
   logic [ofc_pkg::QTY_W-1:0] nb_qty   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    valid_vec, nb_valid, hit_vec, back_vec;
   logic [QUEUE_DEPTH-1:0]    del_vec, shift_vec, load_vec;
   ofc_pkg::slot_ctrl_type    ctrl [QUEUE_DEPTH];

   logic [ofc_pkg::ID_W-1:0]  front_id_in;
   logic [ofc_pkg::QTY_W-1:0] front_qty_in;
   logic                      front_valid_in;
   logic [ofc_pkg::ID_W-1:0]  rem_id;
   logic [ofc_pkg::QTY_W-1:0] rem_qty;

   logic [CW-1:0]             count_ff, count_in;
   logic [ofc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      full, empty, any_hit, push_ok, del_ok;
   ofc_pkg::status_type       status;
   ofc_pkg::rsp_type          rsp;
   logic [ofc_pkg::RSP_W-1:0] rsp_data;
   logic                      buf_ready;

   assign mode    = ofc_pkg::mode_type'(req_tdata[1:0]);
   assign req_id  = req_tdata[32:2];
   assign req_qty = req_tdata[63:33];
   assign req_tready = buf_ready;
   assign req_acc = req_tvalid && buf_ready;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign any_hit = |hit_vec;

   always_comb begin
      status  = ofc_pkg::ST_OK;
      push_ok = 1'b0;
      del_ok  = 1'b0;
      del_vec = '0;
      case (mode)
         ofc_pkg::MODE_APPEND: begin
            if (full) begin
               status = ofc_pkg::ST_FULL;
            end else if (any_hit) begin
               status = ofc_pkg::ST_DUP;
            end else begin
               push_ok = 1'b1;
            end
         end
         ofc_pkg::MODE_POP_FRONT: begin
            if (empty) begin
               status = ofc_pkg::ST_EMPTY;
            end else begin
               del_ok     = 1'b1;
               del_vec[0] = 1'b1;
            end
         end
         ofc_pkg::MODE_POP_BACK: begin
            if (empty) begin
               status = ofc_pkg::ST_EMPTY;
            end else begin
               del_ok  = 1'b1;
               del_vec = back_vec;
            end
         end
         ofc_pkg::MODE_CANCEL: begin
            // An empty queue has no valid slot, so it never hits.
            if (!any_hit) begin
               status = ofc_pkg::ST_NOT_FOUND;
            end else begin
               del_ok  = 1'b1;
               del_vec = hit_vec;
            end
         end
         default: begin
            status = ofc_pkg::ST_OK;
         end
      endcase
   end

   // Slots at and behind the removed one take their neighbor's contents.
   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_slot
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign nb_id[gi]    = '0;
            assign nb_qty[gi]   = '0;
            assign nb_valid[gi] = 1'b0;
            assign back_vec[gi] = valid_vec[gi];
         end else begin : g_mid
            assign nb_id[gi]    = slot_id[gi+1];
            assign nb_qty[gi]   = slot_qty[gi+1];
            assign nb_valid[gi] = valid_vec[gi+1];
            assign back_vec[gi] = valid_vec[gi] && !valid_vec[gi+1];
         end
         if (gi == 0) begin : g_first
            assign shift_vec[gi] = del_vec[gi];
            assign load_vec[gi]  = push_ok && !valid_vec[gi];
         end else begin : g_rest
            assign shift_vec[gi] = shift_vec[gi-1] || del_vec[gi];
            assign load_vec[gi]  = push_ok && !valid_vec[gi] && valid_vec[gi-1];
         end
         assign ctrl[gi].shift = shift_vec[gi];
         assign ctrl[gi].load  = load_vec[gi];

         if (gi == 0) begin : g_front
            ofc_slot u_slot (
               .clock     (clock),
               .reset     (reset),
               .en        (req_acc),
               .ctrl      (ctrl[gi]),
               .req_id    (req_id),
               .req_qty   (req_qty),
               .nb_id     (nb_id[gi]),
               .nb_qty    (nb_qty[gi]),
               .nb_valid  (nb_valid[gi]),
               .id        (slot_id[gi]),
               .qty       (slot_qty[gi]),
               .valid     (valid_vec[gi]),
               .hit       (hit_vec[gi]),
               .nxt_id    (front_id_in),
               .nxt_qty   (front_qty_in),
               .nxt_valid (front_valid_in)
            );
         end else begin : g_back
            logic [ofc_pkg::ID_W-1:0]  unused_id;
            logic [ofc_pkg::QTY_W-1:0] unused_qty;
            logic                      unused_valid;
            ofc_slot u_slot (
               .clock     (clock),
               .reset     (reset),
               .en        (req_acc),
               .ctrl      (ctrl[gi]),
               .req_id    (req_id),
               .req_qty   (req_qty),
               .nb_id     (nb_id[gi]),
               .nb_qty    (nb_qty[gi]),
               .nb_valid  (nb_valid[gi]),
               .id        (slot_id[gi]),
               .qty       (slot_qty[gi]),
               .valid     (valid_vec[gi]),
               .hit       (hit_vec[gi]),
               .nxt_id    (unused_id),
               .nxt_qty   (unused_qty),
               .nxt_valid (unused_valid)
            );
         end
      end
   endgenerate

   // Ids are unique, so at most one slot is removed and an OR picks it.
   always_comb begin
      rem_id  = '0;
      rem_qty = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         rem_id  = rem_id  | (slot_id[i]  & {ofc_pkg::ID_W{del_vec[i]}});
         rem_qty = rem_qty | (slot_qty[i] & {ofc_pkg::QTY_W{del_vec[i]}});
      end
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + ofc_pkg::SUM_W'(req_qty);
      end else if (del_ok) begin
         count_in = count_ff - 1'b1;
         sum_in   = sum_ff - ofc_pkg::SUM_W'(rem_qty);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (req_acc) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_comb begin
      rsp.status      = status;
      rsp.removed_id  = rem_id;
      rsp.removed_qty = rem_qty;
      rsp.front_id    = front_valid_in ? front_id_in  : '0;
      rsp.front_qty   = front_valid_in ? front_qty_in : '0;
      rsp.entry_count = ofc_pkg::CNT_W'(count_in);
      rsp.total_qty   = sum_in;
   end

   assign rsp_data = rsp;

   logic [ofc_pkg::RSP_W-1:0] out_data;

   ofc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (buf_ready),
      .in_data   (rsp_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = ofc_pkg::RSP_PAD'(out_data);

   `OFC_ASSERT_IMPLIES(a_count_matches_valid, clock, reset, 1'b1, count_ff == CW'($countones(valid_vec)))
   `OFC_ASSERT_IMPLIES(a_hit_unique, clock, reset, 1'b1, $onehot0(hit_vec))
   `OFC_ASSERT_IMPLIES(a_del_unique, clock, reset, 1'b1, $onehot0(del_vec))
   `OFC_ASSERT_NEXT(a_push_grows, clock, reset, req_acc && push_ok, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- tb/order_fifo_with_cancel_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order FIFO with cancel: testbench
// Streams append, pop and cancel transactions through the order queue with
// random gaps on both sides and a long receiver stall. Each transaction is
// predicted from a local copy of the resting orders, and every response is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module order_fifo_with_cancel_tb;

   localparam int DEPTH       = 64;
   localparam int RAND_ORDERS = 1550;
   localparam logic [ofc_pkg::ID_W-1:0] ID_MAX = {ofc_pkg::ID_W{1'b1}};

   typedef struct packed {
      logic [ofc_pkg::QTY_W-1:0] qty;
      logic [ofc_pkg::ID_W-1:0]  id;
      ofc_pkg::mode_type         mode;
   } order_req_type;

   typedef struct packed {
      logic [ofc_pkg::ID_W-1:0]  id;
      logic [ofc_pkg::QTY_W-1:0] qty;
   } resting_order_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ofc_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [ofc_pkg::RSP_PAD-1:0]   rsp_tdata;

   order_req_type     order_feed[$];
   ofc_pkg::rsp_type  book_expect[$];
   resting_order_type book[$];
   logic [ofc_pkg::SUM_W-1:0] book_total = '0;

   logic [ofc_pkg::ID_W-1:0] id_pool[128];
   int              pool_head = 0;
   int              pool_fill = 0;

   order_req_type on_bus;
   int  send_gap     = 0;
   int  recv_gap     = 0;
   bit  send_steady  = 1'b0;
   bit  recv_steady  = 1'b0;
   bit  squeeze_done = 1'b0;
   int  rsp_seen     = 0;
   int  mismatch_cnt = 0;

   order_fifo_with_cancel #(.QUEUE_DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one transaction to the local order book and returns its response.
   function automatic ofc_pkg::rsp_type book_apply(input order_req_type r);
      ofc_pkg::rsp_type res;
      int      hit;
      int      victim;
      res = '0;
      res.status = ofc_pkg::ST_OK;
      hit = -1;
      victim = -1;
      for (int i = 0; i < book.size(); i++) begin
         if (hit < 0 && book[i].id == r.id) hit = i;
      end
      case (r.mode)
         ofc_pkg::MODE_APPEND: begin
            // A full book rejects before the duplicate test is looked at.
            if (book.size() >= DEPTH) res.status = ofc_pkg::ST_FULL;
            else if (hit >= 0) res.status = ofc_pkg::ST_DUP;
            else begin
               book.push_back('{id: r.id, qty: r.qty});
               book_total = book_total + ofc_pkg::SUM_W'(r.qty);
            end
         end
         ofc_pkg::MODE_POP_FRONT, ofc_pkg::MODE_POP_BACK: begin
            if (book.size() == 0) res.status = ofc_pkg::ST_EMPTY;
            else victim = (r.mode == ofc_pkg::MODE_POP_FRONT) ? 0 : book.size() - 1;
         end
         default: begin
            if (hit < 0) res.status = ofc_pkg::ST_NOT_FOUND;
            else victim = hit;
         end
      endcase
      if (victim >= 0) begin
         res.removed_id  = book[victim].id;
         res.removed_qty = book[victim].qty;
         book_total = book_total - ofc_pkg::SUM_W'(book[victim].qty);
         book.delete(victim);
      end
      if (book.size() > 0) begin
         res.front_id  = book[0].id;
         res.front_qty = book[0].qty;
      end
      res.entry_count = ofc_pkg::CNT_W'(book.size());
      res.total_qty   = book_total;
      return res;
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one; a steady
   // stretch gives no gaps at all until it flips back.
   function automatic int gap_len(inout bit steady);
      int roll;
      if ($urandom_range(0, 99) < 3) steady = !steady;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [ofc_pkg::ID_W-1:0] pick_id(input int pool_pct);
      int span;
      int roll;
      roll = $urandom_range(0, 99);
      span = (pool_fill < 64) ? pool_fill : 64;
      if (span > 0 && roll < pool_pct)
         return id_pool[(pool_head + 128 - 1 - $urandom_range(0, span - 1)) % 128];
      if (roll > 95) return ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
      if (roll > 80) return ofc_pkg::ID_W'($urandom_range(0, 31));
      return ofc_pkg::ID_W'($urandom);
   endfunction

   function automatic logic [ofc_pkg::QTY_W-1:0] pick_qty();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 25) return ID_MAX;
      return ofc_pkg::QTY_W'($urandom);
   endfunction

   task automatic queue_order(input ofc_pkg::mode_type m,
                              input logic [ofc_pkg::ID_W-1:0] id,
                              input logic [ofc_pkg::QTY_W-1:0] qty);
      order_feed.push_back('{qty: qty, id: id, mode: m});
      if (m == ofc_pkg::MODE_APPEND) begin
         id_pool[pool_head] = id;
         pool_head = (pool_head + 1) % 128;
         pool_fill++;
      end
   endtask

   task automatic check_field(input string name,
                              input logic [ofc_pkg::SUM_W-1:0] exp_val,
                              input logic [ofc_pkg::SUM_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatch_cnt++;
      end
   endtask

   // Sender: the bus value changes only when the current transaction has been
   // taken or nothing is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) book_expect.push_back(book_apply(on_bus));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (order_feed.size() > 0) begin
               on_bus = order_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= on_bus;
               send_gap = gap_len(send_steady);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each response and paces rsp_tready.
   always @(posedge clock) begin
      ofc_pkg::rsp_type got;
      ofc_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[ofc_pkg::RSP_W-1:0];
            if (book_expect.size() == 0) begin
               $error("response with no transaction outstanding");
               mismatch_cnt++;
            end else begin
               exp_rsp = book_expect.pop_front();
               check_field("status", exp_rsp.status, got.status);
               check_field("removed_id", exp_rsp.removed_id, got.removed_id);
               check_field("removed_qty", exp_rsp.removed_qty, got.removed_qty);
               check_field("front_id", exp_rsp.front_id, got.front_id);
               check_field("front_qty", exp_rsp.front_qty, got.front_qty);
               check_field("entry_count", exp_rsp.entry_count, got.entry_count);
               check_field("total_qty", exp_rsp.total_qty, got.total_qty);
               check_field("padding", '0, rsp_tdata[ofc_pkg::RSP_PAD-1:ofc_pkg::RSP_W]);
            end
            rsp_seen++;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!squeeze_done && rsp_seen >= 400) begin
            // Hold off long enough for the response buffer to fill and
            // push back on the request side.
            squeeze_done = 1'b1;
            recv_gap = 250;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = gap_len(recv_steady);
         end
      end
   end

   initial begin
      int         bias;
      int         append_pct;
      int         roll;
      logic [ofc_pkg::ID_W-1:0] pick;

      // Directed opening: empty-book corners, field extremes, duplicates
      // and a cancel from the middle of the book.
      queue_order(ofc_pkg::MODE_POP_FRONT, '0, '0);
      queue_order(ofc_pkg::MODE_POP_BACK, ID_MAX, ID_MAX);
      queue_order(ofc_pkg::MODE_CANCEL, '0, '0);
      queue_order(ofc_pkg::MODE_APPEND, '0, '0);
      queue_order(ofc_pkg::MODE_APPEND, ID_MAX, ID_MAX);
      queue_order(ofc_pkg::MODE_APPEND, 31'h5555_5555, 31'h2AAA_AAAA);
      queue_order(ofc_pkg::MODE_APPEND, 31'h2AAA_AAAA, 31'h5555_5555);
      queue_order(ofc_pkg::MODE_APPEND, '0, 31'd5);
      queue_order(ofc_pkg::MODE_APPEND, ID_MAX, '0);
      queue_order(ofc_pkg::MODE_CANCEL, 31'd12345, '0);
      queue_order(ofc_pkg::MODE_CANCEL, ID_MAX, '0);
      queue_order(ofc_pkg::MODE_CANCEL, 31'h5555_5555, '0);
      queue_order(ofc_pkg::MODE_POP_BACK, '0, '0);
      queue_order(ofc_pkg::MODE_POP_FRONT, '0, '0);
      queue_order(ofc_pkg::MODE_POP_FRONT, '0, '0);
      queue_order(ofc_pkg::MODE_POP_BACK, '0, '0);
      queue_order(ofc_pkg::MODE_APPEND, 31'd7, ID_MAX);
      queue_order(ofc_pkg::MODE_CANCEL, 31'd7, '0);
      queue_order(ofc_pkg::MODE_CANCEL, 31'd7, '0);

      // Random part: phases that fill the book to the top, churn it, or
      // drain it, with cancels often and appends sometimes aimed at recent ids.
      bias = 0;
      for (int n = 0; n < RAND_ORDERS; n++) begin
         if (n % 120 == 0) bias = $urandom_range(0, 2);
         append_pct = (bias == 0) ? 80 : (bias == 1) ? 45 : 15;
         roll = $urandom_range(0, 99);
         if (roll < append_pct) begin
            pick = pick_id(12);
            queue_order(ofc_pkg::MODE_APPEND, pick, pick_qty());
         end else begin
            case ($urandom_range(0, 2))
               0: queue_order(ofc_pkg::MODE_POP_FRONT, ofc_pkg::ID_W'($urandom),
                              ofc_pkg::QTY_W'($urandom));
               1: queue_order(ofc_pkg::MODE_POP_BACK, ofc_pkg::ID_W'($urandom),
                              ofc_pkg::QTY_W'($urandom));
               default: queue_order(ofc_pkg::MODE_CANCEL, pick_id(75),
                                    ofc_pkg::QTY_W'($urandom));
            endcase
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (order_feed.size() == 0 && !req_tvalid);
      wait (book_expect.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("order_fifo_with_cancel: match");
      end else begin
         $display("order_fifo_with_cancel: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("order_fifo_with_cancel: mismatch");
      $finish;
   end

endmodule
